@@ hdl/dcipc_pkg.sv @@
// Package with the types, codes and constants of the dual CPU IPC sync and FIFO block.
package dcipc_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 16;
  localparam int WORD_W = 32;
  localparam int REG_W = 16;
  localparam int IRQ_W = 3;

  typedef enum logic [1:0] {
    FUNC_SYNC = 2'd0,
    FUNC_CTRL = 2'd1,
    FUNC_SEND = 2'd2,
    FUNC_RECV = 2'd3
  } func_t;

  localparam logic [REG_W-1:0] SYNC_WR_MASK = 16'h4F00;
  localparam logic [REG_W-1:0] CTRL_WR_MASK = 16'h8404;
  localparam logic [REG_W-1:0] CTRL_RESET = 16'h0101;

  localparam int SYNC_SEND_IRQ = 13;
  localparam int SYNC_IRQ_EN = 14;

  localparam int CTRL_SEND_EMPTY = 0;
  localparam int CTRL_SEND_FULL = 1;
  localparam int CTRL_SEND_IRQ_EN = 2;
  localparam int CTRL_CLEAR = 3;
  localparam int CTRL_RECV_EMPTY = 8;
  localparam int CTRL_RECV_FULL = 9;
  localparam int CTRL_RECV_IRQ_EN = 10;
  localparam int CTRL_ERROR = 14;
  localparam int CTRL_ENABLE = 15;

  localparam int IRQ_SYNC = 0;
  localparam int IRQ_SEND_EMPTY = 1;
  localparam int IRQ_RECV_NOT_EMPTY = 2;

endpackage

@@ hdl/dcipc_in_if.sv @@
// Interface of the bus access channel.
interface dcipc_in_if;
  import dcipc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic              cpu;
  logic [WORD_W-1:0] byte_mask;
  logic [WORD_W-1:0] write_data;

  modport source (output valid, output func, output cpu, output byte_mask,
                  output write_data, input ready);
  modport sink (input valid, input func, input cpu, input byte_mask,
                input write_data, output ready);
endinterface

@@ hdl/dcipc_out_if.sv @@
// Interface of the result channel.
interface dcipc_out_if;
  import dcipc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic [REG_W-1:0]  sync_word;
  logic [REG_W-1:0]  control_word;
  logic [IRQ_W-1:0]  irq_first;
  logic [IRQ_W-1:0]  irq_second;

  modport source (output valid, output read_data, output sync_word, output control_word,
                  output irq_first, output irq_second, input ready);
  modport sink (input valid, input read_data, input sync_word, input control_word,
                input irq_first, input irq_second, output ready);
endinterface

@@ hdl/dual_cpu_ipc_sync_fifo.sv @@
// Top level of the dual CPU IPC block: sync registers and one word FIFO per direction.
//
// Each transfer on in_ch is one bus access by one CPU: a sync write, a FIFO control
// write, a FIFO send or a FIFO receive read. Every access yields exactly one transfer
// on out_ch with the accessing CPU's receive latch, sync and control registers after
// the access, and one pulse per interrupt line for each CPU.
// An access is held in an input stage, processed there and written to the output
// register, which offers the result on out_ch until it is taken. The block takes one
// access per cycle while out_ch does not stall; that rate is set by the single step
// between input stage and output register and by the one read port of the word
// memory, which is read as the access enters the stage.
// When the receiver stalls, the output register holds its result and the input stage
// keeps its access; in_ch.ready falls once both are occupied.
// Reset clears the sync registers, receive latches, FIFO pointers and fill counts and
// sets both control registers to 0x0101. The word memory is not cleared: a word is
// read only after it has been written.
module dual_cpu_ipc_sync_fifo import dcipc_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  dcipc_in_if.sink   in_ch,
  dcipc_out_if.source out_ch
);

  localparam int HEAD_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = HEAD_W + 1;
  localparam int ADDR_W = HEAD_W + 1;

  logic              stage_valid_r;
  func_t             func_r;
  logic              cpu_r;
  logic [WORD_W-1:0] mask_r;
  logic [WORD_W-1:0] data_r;
  logic              fire;
  logic              in_accept;

  logic [REG_W-1:0]  sync_r [2];
  logic [REG_W-1:0]  sync_nxt [2];
  logic [REG_W-1:0]  ctrl_r [2];
  logic [REG_W-1:0]  ctrl_nxt [2];
  logic [WORD_W-1:0] latch_r [2];
  logic [WORD_W-1:0] latch_nxt [2];
  logic [FILL_W-1:0] fill_r [2];
  logic [FILL_W-1:0] fill_nxt [2];
  logic [HEAD_W-1:0] head_r [2];
  logic [HEAD_W-1:0] head_nxt [2];

  logic [REG_W-1:0]  sc, so, cc, co, m16, v16, mm, wv;
  logic [WORD_W-1:0] lc, lo;
  logic [FILL_W-1:0] fc, fo;
  logic [HEAD_W-1:0] hc, ho;
  logic [IRQ_W-1:0]  irq_c, irq_o;
  logic [SUM_W-1:0]  pos_sum;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] front_word;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_read_data_r;
  logic [REG_W-1:0]  out_sync_word_r;
  logic [REG_W-1:0]  out_control_word_r;
  logic [IRQ_W-1:0]  out_irq_first_r;
  logic [IRQ_W-1:0]  out_irq_second_r;

  assign fire = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stage_valid_r || fire;
  assign in_accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= func_t'(in_ch.func);
      cpu_r <= in_ch.cpu;
      mask_r <= in_ch.byte_mask;
      data_r <= in_ch.write_data;
    end
  end

  always_comb begin
    sc = cpu_r ? sync_r[1] : sync_r[0];
    so = cpu_r ? sync_r[0] : sync_r[1];
    cc = cpu_r ? ctrl_r[1] : ctrl_r[0];
    co = cpu_r ? ctrl_r[0] : ctrl_r[1];
    lc = cpu_r ? latch_r[1] : latch_r[0];
    lo = cpu_r ? latch_r[0] : latch_r[1];
    fc = cpu_r ? fill_r[1] : fill_r[0];
    fo = cpu_r ? fill_r[0] : fill_r[1];
    hc = cpu_r ? head_r[1] : head_r[0];
    ho = cpu_r ? head_r[0] : head_r[1];
    irq_c = '0;
    irq_o = '0;
    m16 = mask_r[REG_W-1:0];
    v16 = data_r[REG_W-1:0];
    wv = v16 & m16;
    mm = '0;
    wr_en = 1'b0;
    wr_data = data_r & mask_r;
    pos_sum = {1'b0, hc} + SUM_W'(fc);
    if (pos_sum >= SUM_W'(FIFO_DEPTH)) begin
      pos_sum = pos_sum - SUM_W'(FIFO_DEPTH);
    end
    wr_addr = {cpu_r, pos_sum[HEAD_W-1:0]};

    case (func_r)
      FUNC_SYNC: begin
        mm = m16 & SYNC_WR_MASK;
        sc = (sc & ~mm) | (v16 & mm);
        so[3:0] = (so[3:0] & ~mm[11:8]) | (v16[11:8] & mm[11:8]);
        if (wv[SYNC_SEND_IRQ] && so[SYNC_IRQ_EN]) begin
          irq_o[IRQ_SYNC] = 1'b1;
        end
      end
      FUNC_CTRL: begin
        if (wv[CTRL_CLEAR] && (fc != '0)) begin
          fc = '0;
          hc = '0;
          lo = '0;
          cc[CTRL_SEND_EMPTY] = 1'b1;
          cc[CTRL_SEND_FULL] = 1'b0;
          co[CTRL_RECV_EMPTY] = 1'b1;
          co[CTRL_RECV_FULL] = 1'b0;
          if (cc[CTRL_SEND_IRQ_EN]) begin
            irq_c[IRQ_SEND_EMPTY] = 1'b1;
          end
        end
        if (cc[CTRL_SEND_EMPTY] && !cc[CTRL_SEND_IRQ_EN] && wv[CTRL_SEND_IRQ_EN]) begin
          irq_c[IRQ_SEND_EMPTY] = 1'b1;
        end
        if (!cc[CTRL_RECV_EMPTY] && !cc[CTRL_RECV_IRQ_EN] && wv[CTRL_RECV_IRQ_EN]) begin
          irq_c[IRQ_RECV_NOT_EMPTY] = 1'b1;
        end
        if (wv[CTRL_ERROR]) begin
          cc[CTRL_ERROR] = 1'b0;
        end
        mm = m16 & CTRL_WR_MASK;
        cc = (cc & ~mm) | (v16 & mm);
      end
      FUNC_SEND: begin
        if (cc[CTRL_ENABLE]) begin
          if (fc < FILL_W'(FIFO_DEPTH)) begin
            wr_en = 1'b1;
            fc = fc + FILL_W'(1);
            if (fc == FILL_W'(1)) begin
              cc[CTRL_SEND_EMPTY] = 1'b0;
              co[CTRL_RECV_EMPTY] = 1'b0;
              if (co[CTRL_RECV_IRQ_EN]) begin
                irq_o[IRQ_RECV_NOT_EMPTY] = 1'b1;
              end
            end else if (fc == FILL_W'(FIFO_DEPTH)) begin
              cc[CTRL_SEND_FULL] = 1'b1;
              co[CTRL_RECV_FULL] = 1'b1;
            end
          end else begin
            cc[CTRL_ERROR] = 1'b1;
          end
        end
      end
      default: begin
        if (fo == '0) begin
          cc[CTRL_ERROR] = 1'b1;
        end else begin
          lc = front_word;
          if (cc[CTRL_ENABLE]) begin
            ho = (ho == HEAD_W'(FIFO_DEPTH - 1)) ? '0 : ho + HEAD_W'(1);
            fo = fo - FILL_W'(1);
            if (fo == '0) begin
              cc[CTRL_RECV_EMPTY] = 1'b1;
              co[CTRL_SEND_EMPTY] = 1'b1;
              if (co[CTRL_SEND_IRQ_EN]) begin
                irq_o[IRQ_SEND_EMPTY] = 1'b1;
              end
            end else if (fo == FILL_W'(FIFO_DEPTH - 1)) begin
              cc[CTRL_RECV_FULL] = 1'b0;
              co[CTRL_SEND_FULL] = 1'b0;
            end
          end
        end
      end
    endcase
    wr_en = wr_en && fire;
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (fire) begin
        sync_nxt[i] = (cpu_r == 1'(i)) ? sc : so;
        ctrl_nxt[i] = (cpu_r == 1'(i)) ? cc : co;
        latch_nxt[i] = (cpu_r == 1'(i)) ? lc : lo;
        fill_nxt[i] = (cpu_r == 1'(i)) ? fc : fo;
        head_nxt[i] = (cpu_r == 1'(i)) ? hc : ho;
      end else begin
        sync_nxt[i] = sync_r[i];
        ctrl_nxt[i] = ctrl_r[i];
        latch_nxt[i] = latch_r[i];
        fill_nxt[i] = fill_r[i];
        head_nxt[i] = head_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        sync_r[i] <= '0;
        ctrl_r[i] <= CTRL_RESET;
        latch_r[i] <= '0;
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        sync_r[i] <= sync_nxt[i];
        ctrl_r[i] <= ctrl_nxt[i];
        latch_r[i] <= latch_nxt[i];
        fill_r[i] <= fill_nxt[i];
        head_r[i] <= head_nxt[i];
      end
    end
  end

  // The front word of the FIFO that the entering access reads is fetched with the
  // head pointer that the access now in the stage leaves behind.
  assign rd_addr = {~in_ch.cpu, in_ch.cpu ? head_nxt[0] : head_nxt[1]};

  dcipc_word_ram #(
    .ADDR_W(ADDR_W)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (front_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data_r <= lc;
      out_sync_word_r <= sc;
      out_control_word_r <= cc;
      out_irq_first_r <= cpu_r ? irq_o : irq_c;
      out_irq_second_r <= cpu_r ? irq_c : irq_o;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.read_data = out_read_data_r;
  assign out_ch.sync_word = out_sync_word_r;
  assign out_ch.control_word = out_control_word_r;
  assign out_ch.irq_first = out_irq_first_r;
  assign out_ch.irq_second = out_irq_second_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_W'(FIFO_DEPTH)) && (fill_r[1] <= FILL_W'(FIFO_DEPTH)))
    else $error("FIFO fill count exceeds the depth");

  a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r[0][CTRL_SEND_EMPTY] == (fill_r[0] == '0)) &&
    (ctrl_r[1][CTRL_RECV_EMPTY] == (fill_r[0] == '0)) &&
    (ctrl_r[1][CTRL_SEND_EMPTY] == (fill_r[1] == '0)) &&
    (ctrl_r[0][CTRL_RECV_EMPTY] == (fill_r[1] == '0)))
    else $error("Empty flags disagree with the fill counts");

  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r[0][CTRL_SEND_FULL] == (fill_r[0] == FILL_W'(FIFO_DEPTH))) &&
    (ctrl_r[1][CTRL_RECV_FULL] == (fill_r[0] == FILL_W'(FIFO_DEPTH))) &&
    (ctrl_r[1][CTRL_SEND_FULL] == (fill_r[1] == FILL_W'(FIFO_DEPTH))) &&
    (ctrl_r[0][CTRL_RECV_FULL] == (fill_r[1] == FILL_W'(FIFO_DEPTH))))
    else $error("Full flags disagree with the fill counts");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> (fill_r[0] == $past(fill_r[0])) && (fill_r[1] == $past(fill_r[1])) &&
              (head_r[0] == $past(head_r[0])) && (head_r[1] == $past(head_r[1])))
    else $error("FIFO state changed without a processed transfer");

endmodule

@@ hdl/dcipc_word_ram.sv @@
// FIFO word memory with one write port and a registered read port with write bypass.
module dcipc_word_ram import dcipc_pkg::*; #(
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem_r [2**ADDR_W];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] byp_data_r;
  logic              byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same word in the same cycle sees the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      byp_r <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_data_r;

endmodule
